>>> design/qia_pkg.sv
// Package for the quantized int8 add block: widths, defaults and register indexes.
// Used by quantized_int8_add, its checker and the testbench; depends on nothing else.
`default_nettype none

package qia_pkg;

  // Fixed field widths
  localparam int unsigned ElemW   = 8;
  localparam int unsigned MultW   = 32;
  localparam int unsigned LanesW  = 64;
  localparam int unsigned PaddrW  = 5;
  localparam int unsigned PdataW  = 32;
  // Element widened by one bit so int8 and uint8 share one signed multiplier
  localparam int unsigned XElemW  = ElemW + 1;
  localparam int unsigned ProdW   = XElemW + MultW;
  // offset + two products: two more bits than one product
  localparam int unsigned AccW    = ProdW + 2;

  // Parameter defaults
  localparam int unsigned LanesDefault    = 8;
  localparam int unsigned FracBitsDefault = 16;

  // Register reset values
  localparam logic [MultW-1:0] AMultReset  = 32'h0001_0000;
  localparam logic [MultW-1:0] BMultReset  = 32'h0001_0000;
  localparam logic [MultW-1:0] OffsetReset = 32'h0000_0000;

  // Register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_A_MULT          = 3'd0,
    REG_B_MULT          = 3'd1,
    REG_OFFSET          = 3'd2,
    REG_RELU_ENABLE     = 3'd3,
    REG_SIGNED_ELEMENTS = 3'd4
  } reg_idx_e;

endpackage

`default_nettype wire

>>> design/quantized_int8_add.sv
// Quantized element-wise add of eight packed int8/uint8 lanes.
// An accepted input word passes the input, accumulator and result registers to its output word;
// throughput one word per cycle while the output is not stalled.
// Each pipeline stage has its own valid bit, so bubbles close up under output stall.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads the register defaults.
// Depends on qia_pkg.
`default_nettype none

module quantized_int8_add #(
  parameter int unsigned LANES     = qia_pkg::LanesDefault,
  parameter int unsigned FRAC_BITS = qia_pkg::FracBitsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Input stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [63:0] a_lanes, [127:64] b_lanes
  input  wire logic [2*qia_pkg::LanesW-1:0]  s_axis_tdata,
  // Output stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [63:0] c_lanes
  output logic [qia_pkg::LanesW-1:0]         m_axis_tdata,
  // Configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [qia_pkg::PaddrW-1:0]    paddr,
  input  wire logic [qia_pkg::PdataW-1:0]    pwdata,
  output logic [qia_pkg::PdataW-1:0]         prdata,
  output logic                               pready
);

  localparam int unsigned LW    = LANES * qia_pkg::ElemW;
  localparam int unsigned AccW  = qia_pkg::AccW;
  localparam int unsigned RndW  = AccW + 1;
  localparam logic [RndW-1:0] Half = RndW'(1) << (FRAC_BITS - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [qia_pkg::MultW-1:0] a_mult_q, b_mult_q, offset_q;
  logic                      relu_enable_q, signed_elements_q;
  logic                      cfg_wr;
  qia_pkg::reg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = qia_pkg::reg_idx_e'(paddr[qia_pkg::PaddrW-1:2]);

  // Write the addressed register in the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_mult_q          <= qia_pkg::AMultReset;
      b_mult_q          <= qia_pkg::BMultReset;
      offset_q          <= qia_pkg::OffsetReset;
      relu_enable_q     <= 1'b0;
      signed_elements_q <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        qia_pkg::REG_A_MULT:          a_mult_q          <= pwdata;
        qia_pkg::REG_B_MULT:          b_mult_q          <= pwdata;
        qia_pkg::REG_OFFSET:          offset_q          <= pwdata;
        qia_pkg::REG_RELU_ENABLE:     relu_enable_q     <= pwdata[0];
        qia_pkg::REG_SIGNED_ELEMENTS: signed_elements_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_idx)
      qia_pkg::REG_A_MULT:          prdata = a_mult_q;
      qia_pkg::REG_B_MULT:          prdata = b_mult_q;
      qia_pkg::REG_OFFSET:          prdata = offset_q;
      qia_pkg::REG_RELU_ENABLE:     prdata = qia_pkg::PdataW'(relu_enable_q);
      qia_pkg::REG_SIGNED_ELEMENTS: prdata = qia_pkg::PdataW'(signed_elements_q);
      default:                      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control
  // ---------------------------------------------------------------------------
  logic in_vld_q, acc_vld_q, out_vld_q;
  logic out_en, acc_en, in_en;

  assign out_en = !out_vld_q || m_axis_tready;
  assign acc_en = !acc_vld_q || out_en;
  assign in_en  = !in_vld_q  || acc_en;

  assign s_axis_tready = in_en;
  assign m_axis_tvalid = out_vld_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      acc_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_en)  in_vld_q  <= s_axis_tvalid;
      if (acc_en) acc_vld_q <= in_vld_q;
      if (out_en) out_vld_q <= acc_vld_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic [LW-1:0] a_q, b_q;

  always_ff @(posedge clk_i) begin
    if (in_en) begin
      a_q <= s_axis_tdata[LW-1:0];
      b_q <= s_axis_tdata[qia_pkg::LanesW +: LW];
    end
  end

  // ---------------------------------------------------------------------------
  // Per-lane multiply-accumulate and requantize
  // ---------------------------------------------------------------------------
  logic signed [AccW-1:0] acc_q [LANES];
  logic [LW-1:0]          c_d;
  logic [LW-1:0]          c_q;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic [qia_pkg::ElemW-1:0]         a_raw, b_raw;
    logic signed [qia_pkg::XElemW-1:0] a_x, b_x;
    logic signed [qia_pkg::ProdW-1:0]  prod_a, prod_b;
    logic signed [AccW-1:0]            acc_d;
    logic                              neg;
    logic [AccW-1:0]                   mag;
    logic [RndW-1:0]                   rnd, m;
    logic [qia_pkg::ElemW-1:0]         pos_lim, res;

    // Widen each element by its sign (int8) or a zero (uint8)
    assign a_raw = a_q[i*qia_pkg::ElemW +: qia_pkg::ElemW];
    assign b_raw = b_q[i*qia_pkg::ElemW +: qia_pkg::ElemW];
    assign a_x   = $signed({signed_elements_q & a_raw[qia_pkg::ElemW-1], a_raw});
    assign b_x   = $signed({signed_elements_q & b_raw[qia_pkg::ElemW-1], b_raw});

    assign prod_a = a_x * $signed(a_mult_q);
    assign prod_b = b_x * $signed(b_mult_q);
    assign acc_d  = AccW'(prod_a) + AccW'(prod_b) + AccW'($signed(offset_q));

    always_ff @(posedge clk_i) begin
      if (acc_en) acc_q[i] <= acc_d;
    end

    // Round half away from zero on the magnitude, then saturate
    assign neg     = acc_q[i][AccW-1];
    assign mag     = neg ? AccW'(-acc_q[i]) : AccW'(acc_q[i]);
    assign rnd     = {1'b0, mag} + Half;
    assign m       = rnd >> FRAC_BITS;
    assign pos_lim = signed_elements_q ? 8'h7F : 8'hFF;

    always_comb begin
      if (!neg) begin
        res = (m > RndW'(pos_lim)) ? pos_lim : m[qia_pkg::ElemW-1:0];
      end else if (!signed_elements_q || relu_enable_q) begin
        // Negative results clamp to zero in uint8 mode or under ReLU
        res = '0;
      end else begin
        res = (m > RndW'(8'h80)) ? 8'h80 : qia_pkg::ElemW'(-m[qia_pkg::ElemW-1:0]);
      end
    end

    assign c_d[i*qia_pkg::ElemW +: qia_pkg::ElemW] = res;
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (out_en) c_q <= c_d;
  end

  // Bytes above the last lane read as zero
  assign m_axis_tdata = qia_pkg::LanesW'(c_q);

endmodule

`default_nettype wire

>>> design/qia_checker.sv
// Port-level checker for quantized_int8_add, bound into that module.
// Depends on qia_pkg for port widths.
`default_nettype none

module qia_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         s_axis_tvalid,
  input wire logic                         s_axis_tready,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready,
  input wire logic [qia_pkg::LanesW-1:0]   m_axis_tdata
);

  logic in_word;
  assign in_word = s_axis_tvalid & s_axis_tready & rst_ni;

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

  // Stalled output word keeps its valid
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped under stall");

  // Stalled output word keeps its data
  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output data changed under stall");

  // With the sink ready, an accepted input word passes the input, accumulator and result registers to the output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_word, 2) && $past(m_axis_tready) && m_axis_tready |=> m_axis_tvalid)
    else $error("input word did not reach the output in three cycles");

endmodule

bind quantized_int8_add qia_checker u_qia_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for quantized_int8_add: streams operand words, predicts each sum.
// Depends on qia_pkg and design/quantized_int8_add.sv.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned Lanes       = qia_pkg::LanesDefault;
  localparam int unsigned FracBits    = qia_pkg::FracBitsDefault;
  localparam longint      HalfUlp     = longint'(1) << (FracBits - 1);
  localparam int unsigned PipeLatency = 3;
  localparam int unsigned UnusedIdxLo = 5;
  localparam int unsigned UnusedIdxHi = 7;
  localparam int unsigned PhaseItems  = 190;
  localparam longint      LimitNs     = 4_000_000;

  localparam logic [31:0] MultMin = 32'h8000_0000;
  localparam logic [31:0] MultMax = 32'h7FFF_FFFF;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  // [63:0] a_lanes, [127:64] b_lanes
  logic [2*qia_pkg::LanesW-1:0]  s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  // [63:0] c_lanes
  logic [qia_pkg::LanesW-1:0]    m_axis_tdata;
  logic                          psel          = 1'b0;
  logic                          penable       = 1'b0;
  logic                          pwrite        = 1'b0;
  logic [qia_pkg::PaddrW-1:0]    paddr         = '0;
  logic [qia_pkg::PdataW-1:0]    pwdata        = '0;
  logic [qia_pkg::PdataW-1:0]    prdata;
  logic                          pready;

  // Shadow copy of the configuration registers
  logic signed [31:0]    cfg_a_mult    = qia_pkg::AMultReset;
  logic signed [31:0]    cfg_b_mult    = qia_pkg::BMultReset;
  logic signed [31:0]    cfg_offset    = qia_pkg::OffsetReset;
  logic                  cfg_relu      = 1'b0;
  logic                  cfg_signed    = 1'b1;

  logic [qia_pkg::LanesW-1:0] expected_sums[$];
  int unsigned           mismatch_count = 0;

  // Sender and receiver pacing
  int unsigned           tx_gap_max    = 0;
  int unsigned           tx_burst_left = 0;
  int unsigned           rx_stall_pct  = 0;
  int unsigned           rx_run_left   = 0;
  logic                  rx_stalled    = 1'b0;
  int unsigned           hold_request  = 0;
  int unsigned           hold_left     = 0;

  quantized_int8_add dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #(LimitNs);
    $display("%0t: timeout with %0d sums outstanding", $time, expected_sums.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Per-lane scaled sum: round half away from zero, saturate, optional ReLU
  function automatic logic [qia_pkg::LanesW-1:0] predict_sum(
    logic [qia_pkg::LanesW-1:0] a,
    logic [qia_pkg::LanesW-1:0] b
  );
    logic [qia_pkg::LanesW-1:0] c;
    logic signed [7:0]  sa;
    logic signed [7:0]  sb;
    longint             ea;
    longint             eb;
    longint             acc;
    longint             r;
    longint             lo;
    longint             hi;
    c  = '0;
    lo = cfg_signed ? -128 : 0;
    hi = cfg_signed ? 127 : 255;
    for (int i = 0; i < Lanes; i++) begin
      sa = a[8*i +: 8];
      sb = b[8*i +: 8];
      if (cfg_signed) begin
        ea = sa;
        eb = sb;
      end else begin
        ea = {56'd0, a[8*i +: 8]};
        eb = {56'd0, b[8*i +: 8]};
      end
      acc = longint'(cfg_offset) + ea * longint'(cfg_a_mult) + eb * longint'(cfg_b_mult);
      if (acc < 0) begin
        r = -((-acc + HalfUlp) >>> FracBits);
      end else begin
        r = (acc + HalfUlp) >>> FracBits;
      end
      if (r < lo) r = lo;
      if (r > hi) r = hi;
      if (cfg_relu && r < 0) r = 0;
      c[8*i +: 8] = r[7:0];
    end
    return c;
  endfunction

  // Configuration write: setup cycle, then access cycle until pready
  task automatic apb_write(int unsigned idx, logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= qia_pkg::PaddrW'(idx * 4);
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      qia_pkg::REG_A_MULT:          cfg_a_mult = value;
      qia_pkg::REG_B_MULT:          cfg_b_mult = value;
      qia_pkg::REG_OFFSET:          cfg_offset = value;
      qia_pkg::REG_RELU_ENABLE:     cfg_relu   = value[0];
      qia_pkg::REG_SIGNED_ELEMENTS: cfg_signed = value[0];
      default: ;
    endcase
  endtask

  // Configuration read, compared with the shadow copy
  task automatic apb_read_check(qia_pkg::reg_idx_e idx, logic [31:0] want);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= qia_pkg::PaddrW'(idx * 4);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== want) begin
      $display("%0t: register %s read expected %h actual %h", $time, idx.name(), want, prdata);
      mismatch_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_all_regs();
    apb_read_check(qia_pkg::REG_A_MULT, cfg_a_mult);
    apb_read_check(qia_pkg::REG_B_MULT, cfg_b_mult);
    apb_read_check(qia_pkg::REG_OFFSET, cfg_offset);
    apb_read_check(qia_pkg::REG_RELU_ENABLE, {31'd0, cfg_relu});
    apb_read_check(qia_pkg::REG_SIGNED_ELEMENTS, {31'd0, cfg_signed});
  endtask

  task automatic set_config(logic [31:0] am, logic [31:0] bm, logic [31:0] off,
                            logic relu, logic sgn);
    apb_write(qia_pkg::REG_A_MULT, am);
    apb_write(qia_pkg::REG_B_MULT, bm);
    apb_write(qia_pkg::REG_OFFSET, off);
    apb_write(qia_pkg::REG_RELU_ENABLE, {31'd0, relu});
    apb_write(qia_pkg::REG_SIGNED_ELEMENTS, {31'd0, sgn});
    check_all_regs();
  endtask

  // Offer one operand word, in bursts with random gaps; record its sum once accepted
  task automatic send_word(logic [qia_pkg::LanesW-1:0] a, logic [qia_pkg::LanesW-1:0] b);
    int unsigned gap;
    if (tx_burst_left == 0) begin
      gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      tx_burst_left = $urandom_range(1, 16);
    end
    tx_burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_sums.push_back(predict_sum(a, b));
  endtask

  // Drop valid, wait for every sum, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk_i);
    repeat (PipeLatency + 1) @(posedge clk_i);
  endtask

  function automatic logic [qia_pkg::LanesW-1:0] rand_lanes();
    logic [qia_pkg::LanesW-1:0] w;
    logic [7:0]        picks[5] = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'h01};
    w = {$urandom, $urandom};
    // Sprinkle boundary bytes into some words
    if ($urandom_range(0, 3) == 0) begin
      for (int i = 0; i < 8; i++) begin
        if ($urandom_range(0, 1)) w[8*i +: 8] = picks[$urandom_range(0, 4)];
      end
    end
    return w;
  endfunction

  function automatic logic [31:0] rand_mult();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? MultMin : MultMax;
      2:       return 32'd0;
      3:       return $urandom_range(0, 1 << 18);
      4:       return -$urandom_range(0, 1 << 18);
      default: return $urandom_range(1 << 14, 1 << 17);
    endcase
  endfunction

  function automatic logic [31:0] rand_offset();
    case ($urandom_range(0, 4))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? MultMin : MultMax;
      2:       return 32'd0;
      default: return $urandom_range(0, 1) ? $urandom_range(0, 1 << 24)
                                           : -$urandom_range(0, 1 << 24);
    endcase
  endfunction

  // Receiver: run-length stall pattern, plus long hold-off on request
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_run_left == 0) begin
        rx_stalled  = ($urandom_range(0, 99) < rx_stall_pct);
        rx_run_left = rx_stalled ? $urandom_range(1, 6) : $urandom_range(1, 12);
      end
      rx_run_left--;
      m_axis_tready <= !rx_stalled;
    end
  end

  // Compare each output word with the oldest predicted sum
  always @(posedge clk_i) begin : check_output
    logic [qia_pkg::LanesW-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_sums.size() == 0) begin
        $display("%0t: output word %h with no sum expected", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = expected_sums.pop_front();
        if (m_axis_tdata !== want) begin
          $display("%0t: c_lanes expected %h actual %h", $time, want, m_axis_tdata);
          mismatch_count++;
        end
      end
    end
  end

  // Default registers: unit multipliers, signed, no ReLU
  task automatic test_reset_defaults();
    check_all_regs();
    tx_gap_max   = 3;
    rx_stall_pct = 30;
    send_word(64'h0, 64'h0);
    send_word({8{8'h7F}}, {8{8'h7F}});
    send_word({8{8'h80}}, {8{8'h80}});
    send_word({8{8'hFF}}, {8{8'h01}});
    send_word({8{8'hFF}}, {8{8'hFF}});
    send_word(64'h807F_FF00_0102_7F80, 64'h0102_0304_FFFE_0180);
    wait_idle();
  endtask

  // int8 versus uint8 reading of the bytes, and ReLU in both modes
  task automatic test_element_modes();
    set_config(qia_pkg::AMultReset, qia_pkg::BMultReset, qia_pkg::OffsetReset, 1'b0, 1'b0);
    send_word({8{8'hFF}}, {8{8'hFF}});
    send_word(64'h0, 64'h0);
    send_word(64'h807F_FF00_0102_7F80, 64'h0102_0304_FFFE_0180);
    wait_idle();
    // ReLU has no effect on unsigned results
    set_config(qia_pkg::AMultReset, qia_pkg::BMultReset, 32'hFFFE_0000, 1'b1, 1'b0);
    send_word(64'h807F_FF00_0102_7F80, 64'h0102_0304_FFFE_0180);
    wait_idle();
    set_config(qia_pkg::AMultReset, qia_pkg::BMultReset, qia_pkg::OffsetReset, 1'b1, 1'b1);
    send_word({8{8'h80}}, {8{8'h80}});
    send_word(64'h807F_FF00_0102_7F80, 64'h0102_0304_FFFE_0180);
    wait_idle();
  endtask

  // Halfway points round away from zero; offsets just short of half do not
  task automatic test_rounding();
    set_config(32'h0000_8000, 32'd0, qia_pkg::OffsetReset, 1'b0, 1'b1);
    // lanes: 1, -1, 3, -3, 5, 0, 127, -128
    send_word(64'h807F_0005_FD03_FF01, 64'h0);
    wait_idle();
    set_config(32'h0000_8000, 32'd0, 32'hFFFF_8000, 1'b0, 1'b1);
    send_word(64'h807F_0005_FD03_FF01, 64'hFFFF_FFFF_FFFF_FFFF);
    wait_idle();
    set_config(32'd0, 32'd0, 32'h0000_7FFF, 1'b0, 1'b1);
    send_word(64'h0, 64'h0);
    wait_idle();
  endtask

  // Most negative and most positive multipliers and offsets
  task automatic test_extreme_scales();
    set_config(MultMin, MultMax, MultMin, 1'b0, 1'b1);
    send_word({8{8'h80}}, {8{8'h7F}});
    send_word(64'h807F_FF00_0102_7F80, 64'h0102_0304_FFFE_0180);
    wait_idle();
    set_config(MultMax, MultMin, MultMax, 1'b0, 1'b0);
    send_word({8{8'hFF}}, 64'h0);
    wait_idle();
  endtask

  // Writes outside the register map leave every register untouched
  task automatic test_unmapped_write();
    set_config(32'h0001_2345, 32'hFFFF_1234, 32'h0000_4000, 1'b1, 1'b1);
    apb_write(UnusedIdxLo, 32'hFFFF_FFFF);
    apb_write(UnusedIdxHi, 32'h0);
    check_all_regs();
    send_word(64'h807F_FF00_0102_7F80, 64'h0102_0304_FFFE_0180);
    wait_idle();
  endtask

  // Extreme and random configurations, each followed by a stretch of random words
  task automatic test_random_stream();
    logic relu;
    logic sgn;
    for (int phase = 0; phase < 7; phase++) begin
      relu = (phase < 4) ? phase[0] : 1'($urandom_range(0, 1));
      sgn  = (phase < 4) ? phase[1] : 1'($urandom_range(0, 1));
      case (phase)
        0:       set_config(MultMin, MultMax, MultMin, relu, sgn);
        1:       set_config(MultMax, MultMin, MultMax, relu, sgn);
        default: set_config(rand_mult(), rand_mult(), rand_offset(), relu, sgn);
      endcase
      if (phase == 2) begin
        tx_gap_max   = 0;
        rx_stall_pct = 0;
      end else begin
        tx_gap_max   = $urandom_range(0, 8);
        rx_stall_pct = $urandom_range(0, 70);
      end
      repeat (PhaseItems) send_word(rand_lanes(), rand_lanes());
      wait_idle();
    end
  endtask

  // Long receiver hold-off while the sender streams back to back
  task automatic test_backpressure();
    set_config(rand_mult(), rand_mult(), rand_offset(), 1'b0, 1'b1);
    tx_gap_max    = 0;
    tx_burst_left = 0;
    rx_stall_pct  = 0;
    hold_request  = 300;
    repeat (60) send_word(rand_lanes(), rand_lanes());
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);
    test_reset_defaults();
    test_element_modes();
    test_rounding();
    test_extreme_scales();
    test_unmapped_write();
    test_random_stream();
    test_backpressure();
    repeat (4 * PipeLatency) @(posedge clk_i);
    if (mismatch_count == 0 && expected_sums.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
